### rtl/assert_macros.svh
// Concurrent assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define RCDC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define RCDC_CHECK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RCDC_ASSERT(lbl, clk, rstn, prop, msg)
`define RCDC_CHECK(lbl, clk, prop, msg)
`endif
`endif

### rtl/rcdc_pkg.sv
`default_nettype none
package rcdc_pkg;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int TAP_BITS_DEF  = 8;
  localparam int MAX_HEIGHT    = 1024;
  localparam int GEOM_W        = 11;
  localparam int ROW_W         = 10;
  localparam int CFG_W         = 24;
  localparam int CFG_IDX_W     = 3;
  localparam int PIX_W         = 8;
  localparam int RGB_W         = 24;
  localparam int DIV_SPECIAL_SUM   = 16;
  localparam int DIV_SPECIAL_VALUE = 20;
  localparam int PIX_MAX       = 255;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS_TOP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS_MIDDLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS_BOTTOM  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MAC,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;
endpackage
`default_nettype wire

### rtl/rcdc_ram.sv
`default_nettype none
module rcdc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/rcdc_div.sv
`default_nettype none
module rcdc_div #(
  parameter int NUM_W = 21,
  parameter int DEN_W = 12
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r, den_r;
  logic [NUM_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DEN_W:0]   trial, diff;
  logic             ge;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule
`default_nettype wire

### rtl/rgb_conv3x3_divide_clamp_core.sv
// 3x3 RGB convolution with divide and clamp. Pixels enter in raster order;
// the two previous rows sit in one line memory (one entry per column, read
// when a pixel is taken and written back the next cycle). A border pixel
// passes through the accept cycle and one memory read. A pixel that
// completes an interior window passes through the accept cycle, one memory
// read, nine multiply-accumulate steps (one tap per cycle, three planes in
// parallel), a step that latches the signs and starts the divide, a
// restoring divide of one quotient bit per cycle over TAP_BITS + 13 bits
// and a step that finishes it, and a step that loads the output register.
// While the output register holds an unaccepted result, that last step
// repeats. The result for centre (r,c) leaves with pixel (r+1,c+1); tlast
// marks the last interior result of a frame. Writing width or height
// restarts the frame. Line memory contents are not cleared after reset;
// entries not yet written are read but never reach a result.
`default_nettype none
`include "assert_macros.svh"
module rgb_conv3x3_divide_clamp_core #(
  parameter int MAX_WIDTH = rcdc_pkg::MAX_WIDTH_DEF,
  parameter int TAP_BITS  = rcdc_pkg::TAP_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [rcdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rcdc_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // chan_zero_in[7:0], chan_one_in[15:8], chan_two_in[23:16]
  input  wire logic [rcdc_pkg::RGB_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // chan_zero_out[7:0], chan_one_out[15:8], chan_two_out[23:16]
  output logic      [rcdc_pkg::RGB_W-1:0]     out_tdata,
  output logic                                out_tlast
);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int EW    = CW + 1;
  localparam int CMPW  = (EW > rcdc_pkg::GEOM_W) ? EW : rcdc_pkg::GEOM_W;
  localparam int TAPW  = 3 * TAP_BITS;
  localparam int PROD_W = TAP_BITS + rcdc_pkg::PIX_W + 1;
  localparam int ACC_W = TAP_BITS + 13;
  localparam int DEN_W = TAP_BITS + 4;
  localparam int RGB_W = rcdc_pkg::RGB_W;
  localparam int PIX_W = rcdc_pkg::PIX_W;
  localparam int ROW_W = rcdc_pkg::ROW_W;

  rcdc_pkg::state_t state_r, state_nxt;

  logic [rcdc_pkg::GEOM_W-1:0] width_r, height_r;
  logic [TAPW-1:0]             taps_r [3];
  logic [CW-1:0]               col_r, col_hold_r;
  logic [ROW_W-1:0]            row_r;
  logic                        emit_r, last_r;

  logic [EW-1:0]               eff_w;
  logic [rcdc_pkg::GEOM_W-1:0] eff_h;
  logic                        col_last, row_last, accept;

  logic [RGB_W-1:0]            pix_r;
  logic [2*RGB_W-1:0]          ram_rdata, ram_wdata;
  logic                        ram_we;
  logic [RGB_W-1:0]            winreg_r [3][2];
  logic [RGB_W-1:0]            win9_r [9];
  logic signed [TAP_BITS-1:0]  tap9 [9];
  logic signed [DEN_W-1:0]     dsum, dsum_r, dsum_fix;
  logic [3:0]                  k_r;
  logic signed [ACC_W-1:0]     acc_r [3];
  logic                        neg_r [3];
  logic [ACC_W-1:0]            num_mag [3];
  logic [ACC_W-1:0]            quo [3];
  logic                        div_done [3];
  logic [DEN_W-1:0]            den_mag;
  logic                        div_start;
  logic [RGB_W-1:0]            res;

  assign accept = in_tvalid && in_tready;

  always_comb begin
    logic [CMPW-1:0] wext;
    wext = CMPW'(width_r);
    if (width_r < rcdc_pkg::GEOM_W'(3)) begin
      eff_w = EW'(3);
    end else if (wext > CMPW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(wext);
    end
    if (height_r < rcdc_pkg::GEOM_W'(3)) begin
      eff_h = rcdc_pkg::GEOM_W'(3);
    end else if (height_r > rcdc_pkg::GEOM_W'(rcdc_pkg::MAX_HEIGHT)) begin
      eff_h = rcdc_pkg::GEOM_W'(rcdc_pkg::MAX_HEIGHT);
    end else begin
      eff_h = height_r;
    end
  end

  assign col_last = (col_r == CW'(eff_w - EW'(1)));
  assign row_last = (row_r == ROW_W'(eff_h - rcdc_pkg::GEOM_W'(1)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rcdc_pkg::GEOM_W'(1024);
      height_r <= rcdc_pkg::GEOM_W'(1024);
      taps_r[0] <= '0;
      taps_r[1] <= TAPW'(1) << TAP_BITS;
      taps_r[2] <= '0;
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rcdc_pkg::CFG_IMAGE_WIDTH: begin
          width_r <= cfg_wdata[rcdc_pkg::GEOM_W-1:0];
          col_r   <= '0;
          row_r   <= '0;
        end
        rcdc_pkg::CFG_IMAGE_HEIGHT: begin
          height_r <= cfg_wdata[rcdc_pkg::GEOM_W-1:0];
          col_r    <= '0;
          row_r    <= '0;
        end
        rcdc_pkg::CFG_TAPS_TOP:    taps_r[0] <= TAPW'(cfg_wdata);
        rcdc_pkg::CFG_TAPS_MIDDLE: taps_r[1] <= TAPW'(cfg_wdata);
        rcdc_pkg::CFG_TAPS_BOTTOM: taps_r[2] <= TAPW'(cfg_wdata);
        default: ;
      endcase
    end else if (accept) begin
      if (col_last) begin
        col_r <= '0;
        row_r <= row_last ? '0 : row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r      <= in_tdata;
      col_hold_r <= col_r;
      emit_r     <= (row_r >= ROW_W'(2)) && (col_r >= CW'(2));
      last_r     <= row_last && col_last;
    end
  end

  // line memory: [23:0] row r-2, [47:24] row r-1
  assign ram_we    = (state_r == rcdc_pkg::ST_READ);
  assign ram_wdata = {pix_r, ram_rdata[2*RGB_W-1:RGB_W]};

  rcdc_ram #(
    .WIDTH (2 * RGB_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (col_hold_r),
    .wdata (ram_wdata),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    dsum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        tap9[i*3+j] = taps_r[i][j*TAP_BITS +: TAP_BITS];
        dsum = dsum + DEN_W'(tap9[i*3+j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        winreg_r[i][0] <= '0;
        winreg_r[i][1] <= '0;
      end
    end else if (state_r == rcdc_pkg::ST_READ) begin
      win9_r[0] <= winreg_r[0][0];
      win9_r[1] <= winreg_r[0][1];
      win9_r[2] <= ram_rdata[RGB_W-1:0];
      win9_r[3] <= winreg_r[1][0];
      win9_r[4] <= winreg_r[1][1];
      win9_r[5] <= ram_rdata[2*RGB_W-1:RGB_W];
      win9_r[6] <= winreg_r[2][0];
      win9_r[7] <= winreg_r[2][1];
      win9_r[8] <= pix_r;
      winreg_r[0][0] <= winreg_r[0][1];
      winreg_r[0][1] <= ram_rdata[RGB_W-1:0];
      winreg_r[1][0] <= winreg_r[1][1];
      winreg_r[1][1] <= ram_rdata[2*RGB_W-1:RGB_W];
      winreg_r[2][0] <= winreg_r[2][1];
      winreg_r[2][1] <= pix_r;
      dsum_r <= dsum;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == rcdc_pkg::ST_READ) begin
      k_r <= '0;
      for (int ch = 0; ch < 3; ch++) begin
        acc_r[ch] <= '0;
      end
    end else if (state_r == rcdc_pkg::ST_MAC) begin
      k_r <= k_r + 1'b1;
      for (int ch = 0; ch < 3; ch++) begin
        acc_r[ch] <= acc_r[ch] + ACC_W'($signed(PROD_W'(
          $signed({1'b0, win9_r[k_r][ch*PIX_W +: PIX_W]}) * tap9[k_r])));
      end
    end
  end

  always_comb begin
    if (dsum_r == DEN_W'(0)) begin
      dsum_fix = DEN_W'(1);
    end else if (dsum_r == DEN_W'(rcdc_pkg::DIV_SPECIAL_SUM)) begin
      dsum_fix = DEN_W'(rcdc_pkg::DIV_SPECIAL_VALUE);
    end else begin
      dsum_fix = dsum_r;
    end
    den_mag = dsum_fix[DEN_W-1] ? DEN_W'(-dsum_fix) : DEN_W'(dsum_fix);
    for (int ch = 0; ch < 3; ch++) begin
      num_mag[ch] = acc_r[ch][ACC_W-1] ? ACC_W'(-acc_r[ch]) : ACC_W'(acc_r[ch]);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == rcdc_pkg::ST_LOAD) begin
      for (int ch = 0; ch < 3; ch++) begin
        neg_r[ch] <= acc_r[ch][ACC_W-1] ^ dsum_fix[DEN_W-1];
      end
    end
  end

  assign div_start = (state_r == rcdc_pkg::ST_LOAD);

  for (genvar ch = 0; ch < 3; ch++) begin : g_div
    rcdc_div #(
      .NUM_W (ACC_W),
      .DEN_W (DEN_W)
    ) u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .start (div_start),
      .num   (num_mag[ch]),
      .den   (den_mag),
      .done  (div_done[ch]),
      .quo   (quo[ch])
    );

    always_comb begin
      if (neg_r[ch]) begin
        res[ch*PIX_W +: PIX_W] = '0;
      end else if (quo[ch] > ACC_W'(rcdc_pkg::PIX_MAX)) begin
        res[ch*PIX_W +: PIX_W] = PIX_W'(rcdc_pkg::PIX_MAX);
      end else begin
        res[ch*PIX_W +: PIX_W] = quo[ch][PIX_W-1:0];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    unique case (state_r)
      rcdc_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = rcdc_pkg::ST_READ;
        end
      end
      rcdc_pkg::ST_READ: state_nxt = emit_r ? rcdc_pkg::ST_MAC : rcdc_pkg::ST_IDLE;
      rcdc_pkg::ST_MAC: begin
        if (k_r == 4'd8) begin
          state_nxt = rcdc_pkg::ST_LOAD;
        end
      end
      rcdc_pkg::ST_LOAD: state_nxt = rcdc_pkg::ST_DIV;
      rcdc_pkg::ST_DIV: begin
        if (div_done[0]) begin
          state_nxt = rcdc_pkg::ST_DONE;
        end
      end
      rcdc_pkg::ST_DONE: begin
        if (!out_tvalid || out_tready) begin
          state_nxt = rcdc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rcdc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rcdc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (state_r == rcdc_pkg::ST_DONE && (!out_tvalid || out_tready)) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == rcdc_pkg::ST_DONE && (!out_tvalid || out_tready)) begin
      out_tdata <= res;
      out_tlast <= last_r;
    end
  end

  `RCDC_ASSERT(a_accept_reads, clk, rst_n, accept |=> (state_r == rcdc_pkg::ST_READ), "request not followed by line read")
  `RCDC_ASSERT(a_div_done_state, clk, rst_n, div_done[0] |-> (state_r == rcdc_pkg::ST_DIV), "divide finished outside divide state")
  `RCDC_ASSERT(a_out_from_done, clk, rst_n, $rose(out_tvalid) |-> $past(state_r == rcdc_pkg::ST_DONE), "result raised without a finished request")
  `RCDC_CHECK(a_col_in_range, clk, (!rst_n || $past(!rst_n)) || (EW'(col_r) < eff_w), "column counter beyond image width")
endmodule
`default_nettype wire
